@@ design/spwu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spwu_pkg
// Shared codes, types and fixed-point helpers for the pricing weight update.
// ----------------------------------------------------------------------------
package spwu_pkg;

  localparam int MAX_VARS_DEF  = 4096;
  localparam int MAX_ROWS_DEF  = 4096;
  localparam int FRAC_BITS_DEF = 40;

  localparam logic [2:0] REQ_LOAD_W   = 3'd0;
  localparam logic [2:0] REQ_LOAD_RHO = 3'd1;
  localparam logic [2:0] REQ_PIVOT    = 3'd2;
  localparam logic [2:0] REQ_ENTRY    = 3'd3;
  localparam logic [2:0] REQ_READ_W   = 3'd4;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_ACC  = 2'd1;
  localparam logic [1:0] ST_SKIP = 2'd2;

  localparam logic [1:0] MODE_SE = 2'd0;

  localparam logic CFG_STRATEGY = 1'b0;
  localparam logic CFG_COUNT    = 1'b1;

  localparam logic signed [63:0] SMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] SMIN = 64'sh8000_0000_0000_0000;

  typedef enum logic [2:0] {
    AOP_RHO, AOP_R, AOP_R2, AOP_DSE, AOP_DECAY, AOP_INV, AOP_LW1, AOP_LW2
  } aop_t;

  typedef enum logic [1:0] {OSEL_ZERO, OSEL_DATA, OSEL_WRD, OSEL_NEW} osel_t;

  typedef enum logic [1:0] {WSEL_LOAD, WSEL_LEAVE, WSEL_UPD} wsel_t;

  typedef struct packed {
    logic       take;
    logic       w_rd;
    logic       r_rd;
    logic       w_wr;
    wsel_t      wsel;
    logic       r_wr;
    logic       gq_load;
    logic       pivot_set;
    logic       pivot_clr;
    logic       tau_clr;
    logic       a_start;
    aop_t       aop;
    logic       out_load;
    osel_t      osel;
    logic [1:0] ost;
  } spwu_cmd_t;

  typedef struct packed {
    logic [2:0] req;
    logic       var_ok;
    logic       row_ok;
    logic       piv_ok;
    logic       leave_lim;
    logic       act;
    logic       last;
    logic       upd_ok;
    logic       mode0;
    logic       a_done;
    logic       out_free;
  } spwu_stat_t;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      return a[63] ? SMIN : SMAX;
    end
    return s;
  endfunction

  function automatic logic [63:0] mag(input logic signed [63:0] a);
    return a[63] ? (64'd0 - a) : a;
  endfunction

  function automatic logic signed [63:0] signed_sat(input logic neg, input logic [63:0] m,
                                                    input logic over);
    if (neg) begin
      return (over || m[63]) ? SMIN : -$signed(m);
    end
    return (over || m[63]) ? SMAX : $signed(m);
  endfunction

endpackage

@@ design/spwu_arith.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spwu_arith
// Shared multi-cycle unit: rounded saturating fixed-point multiply (four
// 32x32 partial products) and divide (one quotient bit per cycle).
// ----------------------------------------------------------------------------
module spwu_arith
  import spwu_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               is_div,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  output logic               done,
  output logic signed [63:0] res
);

  typedef enum logic [3:0] {
    A_IDLE = 4'b0001, A_MUL = 4'b0010, A_DIV = 4'b0100, A_FIN = 4'b1000
  } astate_t;

  astate_t       state;
  logic [63:0]   ma, mb, rem, q;
  logic [127:0]  acc, dvd;
  logic [6:0]    cnt;
  logic          neg, div_op, over;

  logic [31:0]   xa, xb;
  logic [63:0]   pp;
  logic [127:0]  pp_sh, full;
  logic [64:0]   r1;
  logic          rnd;
  logic [63:0]   q1;

  always_comb begin
    xa = cnt[1] ? ma[63:32] : ma[31:0];
    xb = cnt[0] ? mb[63:32] : mb[31:0];
    pp = xa * xb;
    case ({cnt[1], cnt[0]})
      2'b00:   pp_sh = {64'd0, pp};
      2'b11:   pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
    full = acc + (128'd1 << (FRAC_BITS - 1));
    r1   = {rem, dvd[127]};
    rnd  = (rem >= (mb - rem));
    q1   = q + 64'(rnd);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == A_FIN);
      unique case (state)
        A_IDLE: begin
          if (start) begin
            ma     <= mag(a);
            mb     <= mag(b);
            neg    <= a[63] ^ b[63];
            div_op <= is_div;
            acc    <= '0;
            dvd    <= {64'd0, mag(a)} << FRAC_BITS;
            rem    <= '0;
            q      <= '0;
            over   <= 1'b0;
            cnt    <= '0;
            state  <= is_div ? A_DIV : A_MUL;
          end
        end
        A_MUL: begin
          acc <= acc + pp_sh;
          cnt <= cnt + 7'd1;
          if (cnt[1:0] == 2'd3) begin
            state <= A_FIN;
          end
        end
        A_DIV: begin
          dvd <= dvd << 1;
          if (r1 >= {1'b0, mb}) begin
            rem <= 64'(r1 - {1'b0, mb});
            if (!cnt[6]) begin
              over <= 1'b1;
            end
            q <= {q[62:0], cnt[6]};
          end else begin
            rem <= r1[63:0];
            q   <= {q[62:0], 1'b0};
          end
          cnt <= cnt + 7'd1;
          if (cnt == 7'd127) begin
            state <= A_FIN;
          end
        end
        A_FIN: begin
          if (div_op) begin
            res <= signed_sat(neg, q1, over || (rnd && (q == '1)));
          end else begin
            res <= signed_sat(neg, full[FRAC_BITS +: 64], |full[127:FRAC_BITS + 64]);
          end
          state <= A_IDLE;
        end
        default: state <= A_IDLE;
      endcase
    end
  end

endmodule

@@ design/spwu_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spwu_dp
// Datapath: item registers, weight and rho memories, pivot state, the
// arithmetic unit, configuration registers and the output register.
// ----------------------------------------------------------------------------
module spwu_dp
  import spwu_pkg::*;
#(
  parameter int MAX_VARS  = MAX_VARS_DEF,
  parameter int MAX_ROWS  = MAX_ROWS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  spwu_cmd_t          cmd,
  output spwu_stat_t         stat,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [12:0]        cfg_data,
  input  logic [2:0]         req_type,
  input  logic [11:0]        var_index,
  input  logic [11:0]        row_index,
  input  logic signed [63:0] data_value,
  input  logic [11:0]        leaving_var,
  input  logic               leaving_valid,
  input  logic               column_is_basic,
  input  logic               last_in_column,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] weight_out,
  output logic [1:0]         status
);

  localparam int VA = $clog2(MAX_VARS);
  localparam int RA = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam logic signed [63:0] ONE_Q = 64'sd1 <<< FRAC_BITS;
  localparam logic [63:0] MINW_RAW =
    ((64'd1 << FRAC_BITS) + 64'd5000000000) / 64'd10000000000;
  localparam logic signed [63:0] MINW = (MINW_RAW > 0) ? $signed(MINW_RAW) : 64'sd1;
  localparam logic signed [63:0] DECAY_Q =
    $signed((64'd99 * (64'd1 << FRAC_BITS) + 64'd50) / 64'd100);

  logic [2:0]         in_req;
  logic [11:0]        in_var, in_row, in_leave, ent;
  logic signed [63:0] in_data;
  logic               in_lok, in_basic, in_last;

  logic signed [63:0] wmem [MAX_VARS];
  logic signed [63:0] rmem [MAX_ROWS];
  logic signed [63:0] wrd, rrd;

  logic signed [63:0] tau, invp, fac, gq, t, r2, nw_pre, nwf;
  logic               act;
  logic [1:0]         mode;
  logic [12:0]        wcount;

  logic               var_lim;
  logic signed [63:0] dd, nd, a_op, b_op, a_res, dv;
  logic               a_div, a_done;
  logic [VA-1:0]      waddr;
  logic signed [63:0] wdata;

  always_comb begin
    var_lim = (32'(in_var) < 32'(wcount)) && (32'(in_var) < MAX_VARS);
    nwf     = (nw_pre > MINW) ? nw_pre : MINW;
    dd      = sat_add(in_data, in_data);
    nd      = (dd == SMIN) ? -SMAX : -dd;
    dv      = sat_add(r2, ONE_Q);

    stat.req       = in_req;
    stat.var_ok    = 32'(in_var) < MAX_VARS;
    stat.row_ok    = 32'(in_row) < MAX_ROWS;
    stat.piv_ok    = !mode[1] && (mag(in_data) >= 64'(MINW));
    stat.leave_lim = in_lok && (32'(in_leave) < 32'(wcount)) && (32'(in_leave) < MAX_VARS);
    stat.act       = act;
    stat.last      = in_last;
    stat.upd_ok    = !in_basic && (in_var != ent) && var_lim && !mode[1];
    stat.mode0     = (mode == MODE_SE);
    stat.a_done    = a_done;
    stat.out_free  = !out_valid || !out_stall;

    a_div = 1'b0;
    case (cmd.aop)
      AOP_RHO:   begin a_op = rrd;     b_op = in_data; end
      AOP_R:     begin a_op = tau;     b_op = invp;    end
      AOP_R2:    begin a_op = t;       b_op = t;       end
      AOP_DSE:   begin a_op = r2;      b_op = fac;     end
      AOP_DECAY: begin a_op = DECAY_Q; b_op = wrd;     end
      AOP_INV:   begin a_op = ONE_Q;   b_op = in_data; a_div = 1'b1; end
      AOP_LW1:   begin a_op = gq;      b_op = in_data; a_div = 1'b1; end
      default:   begin a_op = t;       b_op = in_data; a_div = 1'b1; end
    endcase

    case (cmd.wsel)
      WSEL_LOAD:  begin waddr = VA'(in_var);   wdata = in_data; end
      WSEL_LEAVE: begin waddr = VA'(in_leave); wdata = nwf;     end
      default:    begin waddr = VA'(in_var);   wdata = nwf;     end
    endcase
  end

  spwu_arith #(.FRAC_BITS(FRAC_BITS)) u_arith (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.a_start),
    .is_div (a_div),
    .a      (a_op),
    .b      (b_op),
    .done   (a_done),
    .res    (a_res)
  );

  always_ff @(posedge clk) begin
    if (cmd.w_wr) begin
      wmem[waddr] <= wdata;
    end
    if (cmd.w_rd) begin
      wrd <= wmem[VA'(in_var)];
    end
    if (cmd.r_wr) begin
      rmem[RA'(in_row)] <= in_data;
    end
    if (cmd.r_rd) begin
      rrd <= rmem[RA'(in_row)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tau       <= '0;
      ent       <= '0;
      invp      <= '0;
      fac       <= '0;
      act       <= 1'b0;
      mode      <= '0;
      wcount    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.take) begin
        in_req   <= req_type;
        in_var   <= var_index;
        in_row   <= row_index;
        in_data  <= data_value;
        in_leave <= leaving_var;
        in_lok   <= leaving_valid;
        in_basic <= column_is_basic;
        in_last  <= last_in_column;
      end
      if (cmd.gq_load) begin
        if (!var_lim || wrd < MINW) begin
          gq <= ONE_Q;
        end else begin
          gq <= wrd;
        end
      end
      if (a_done) begin
        case (cmd.aop)
          AOP_RHO:   ;
          AOP_R:     t      <= a_res;
          AOP_R2:    r2     <= a_res;
          AOP_DSE:   nw_pre <= sat_add(wrd, a_res);
          AOP_DECAY: nw_pre <= (dv > a_res) ? dv : a_res;
          AOP_INV:   invp   <= a_res;
          AOP_LW1:   t      <= a_res;
          default:   nw_pre <= a_res;
        endcase
      end
      if (cmd.pivot_clr || cmd.tau_clr || (cmd.a_start && cmd.aop == AOP_R)) begin
        tau <= '0;
      end else if (a_done && cmd.aop == AOP_RHO) begin
        tau <= sat_add(tau, a_res);
      end
      if (cmd.pivot_clr) begin
        act <= 1'b0;
      end else if (cmd.pivot_set) begin
        act <= 1'b1;
      end
      if (cmd.pivot_set) begin
        ent <= in_var;
        fac <= sat_add(sat_add(gq, nd), ONE_Q);
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_STRATEGY: mode   <= cfg_data[1:0];
          CFG_COUNT:    wcount <= cfg_data;
          default:      ;
        endcase
      end
      out_valid <= cmd.out_load || (out_valid && out_stall);
      if (cmd.out_load) begin
        status <= cmd.ost;
        case (cmd.osel)
          OSEL_ZERO: weight_out <= '0;
          OSEL_DATA: weight_out <= in_data;
          OSEL_WRD:  weight_out <= wrd;
          default:   weight_out <= nwf;
        endcase
      end
    end
  end

endmodule

@@ design/spwu_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spwu_ctrl
// Controller: decodes each item and sequences memory access, the arithmetic
// unit and the result transfer.
// ----------------------------------------------------------------------------
module spwu_ctrl
  import spwu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  spwu_stat_t stat,
  output spwu_cmd_t  cmd
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_DEC    = 10'b0000000010,
    S_PV_GQ  = 10'b0000000100,
    S_PV_FAC = 10'b0000001000,
    S_AGO    = 10'b0000010000,
    S_AWT    = 10'b0000100000,
    S_CHK    = 10'b0001000000,
    S_WLV    = 10'b0010000000,
    S_WUP    = 10'b0100000000,
    S_OUT    = 10'b1000000000
  } state_t;

  state_t     state, state_next;
  aop_t       aop, aop_next;
  osel_t      osel, osel_next;
  logic [1:0] ost, ost_next;

  always_comb begin
    state_next = state;
    aop_next   = aop;
    osel_next  = osel;
    ost_next   = ost;
    cmd        = '0;
    cmd.aop    = aop;
    cmd.osel   = osel;
    cmd.ost    = ost;
    cmd.wsel   = WSEL_LOAD;
    in_stall   = (state != S_IDLE);

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        osel_next  = OSEL_ZERO;
        ost_next   = ST_SKIP;
        state_next = S_OUT;
        case (stat.req)
          REQ_LOAD_W: begin
            if (stat.var_ok) begin
              cmd.w_wr  = 1'b1;
              osel_next = OSEL_DATA;
              ost_next  = ST_DONE;
            end
          end
          REQ_LOAD_RHO: begin
            if (stat.row_ok) begin
              cmd.r_wr = 1'b1;
              ost_next = ST_DONE;
            end
          end
          REQ_READ_W: begin
            if (stat.var_ok) begin
              cmd.w_rd  = 1'b1;
              osel_next = OSEL_WRD;
              ost_next  = ST_DONE;
            end
          end
          REQ_PIVOT: begin
            cmd.pivot_clr = 1'b1;
            if (stat.piv_ok) begin
              cmd.w_rd   = 1'b1;
              state_next = S_PV_GQ;
            end
          end
          REQ_ENTRY: begin
            if (stat.act) begin
              if (stat.row_ok) begin
                cmd.r_rd   = 1'b1;
                aop_next   = AOP_RHO;
                state_next = S_AGO;
              end else begin
                state_next = S_CHK;
              end
            end
          end
          default: ;
        endcase
      end
      S_PV_GQ: begin
        cmd.gq_load = 1'b1;
        state_next  = S_PV_FAC;
      end
      S_PV_FAC: begin
        cmd.pivot_set = 1'b1;
        aop_next      = AOP_INV;
        state_next    = S_AGO;
      end
      S_AGO: begin
        cmd.a_start = 1'b1;
        state_next  = S_AWT;
      end
      S_AWT: begin
        if (stat.a_done) begin
          state_next = S_AGO;
          case (aop)
            AOP_INV: begin
              if (stat.leave_lim) begin
                aop_next = AOP_LW1;
              end else begin
                osel_next  = OSEL_ZERO;
                ost_next   = ST_DONE;
                state_next = S_OUT;
              end
            end
            AOP_LW1: aop_next   = AOP_LW2;
            AOP_LW2: state_next = S_WLV;
            AOP_RHO: state_next = S_CHK;
            AOP_R:   aop_next   = AOP_R2;
            AOP_R2:  aop_next   = stat.mode0 ? AOP_DSE : AOP_DECAY;
            default: state_next = S_WUP;
          endcase
        end
      end
      S_CHK: begin
        osel_next  = OSEL_ZERO;
        state_next = S_OUT;
        if (!stat.last) begin
          ost_next = ST_ACC;
        end else if (stat.upd_ok) begin
          cmd.w_rd   = 1'b1;
          aop_next   = AOP_R;
          state_next = S_AGO;
        end else begin
          cmd.tau_clr = 1'b1;
          ost_next    = ST_SKIP;
        end
      end
      S_WLV: begin
        cmd.w_wr   = 1'b1;
        cmd.wsel   = WSEL_LEAVE;
        osel_next  = OSEL_NEW;
        ost_next   = ST_DONE;
        state_next = S_OUT;
      end
      S_WUP: begin
        cmd.w_wr   = 1'b1;
        cmd.wsel   = WSEL_UPD;
        osel_next  = OSEL_NEW;
        ost_next   = ST_DONE;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
    aop  <= aop_next;
    osel <= osel_next;
    ost  <= ost_next;
  end

endmodule

@@ design/simplex_pricing_weight_update.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// simplex_pricing_weight_update
// Steepest-edge / Devex pricing weight store with pivot start, sparse column
// dot product and saturating Q23.40 weight update.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_stall  | req_type .. last_in_column
//   out     | output    | out_valid / out_stall| weight_out, status
//   cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One item at a time. A column's last entry with an update runs up to four
// multiplies on the shared 32x32 multiplier and a pivot start up to three
// divides at one quotient bit per cycle. Synchronous reset clears control
// and pivot state; the weight and rho memories are not cleared. A stalled
// result holds in the output register while the next item's work runs up
// to its own result.
// ----------------------------------------------------------------------------
module simplex_pricing_weight_update
  import spwu_pkg::*;
#(
  parameter int MAX_VARS  = MAX_VARS_DEF,
  parameter int MAX_ROWS  = MAX_ROWS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         req_type,
  input  logic [11:0]        var_index,
  input  logic [11:0]        row_index,
  input  logic signed [63:0] data_value,
  input  logic [11:0]        leaving_var,
  input  logic               leaving_valid,
  input  logic               column_is_basic,
  input  logic               last_in_column,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] weight_out,
  output logic [1:0]         status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [12:0]        cfg_data
);

  spwu_cmd_t  cmd;
  spwu_stat_t stat;

  assign cfg_ready = 1'b1;

  spwu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  spwu_dp #(
    .MAX_VARS  (MAX_VARS),
    .MAX_ROWS  (MAX_ROWS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .req_type        (req_type),
    .var_index       (var_index),
    .row_index       (row_index),
    .data_value      (data_value),
    .leaving_var     (leaving_var),
    .leaving_valid   (leaving_valid),
    .column_is_basic (column_is_basic),
    .last_in_column  (last_in_column),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .weight_out      (weight_out),
    .status          (status)
  );

endmodule
